[rtl/core/slcd_pkg.sv]
package slcd_pkg;

    localparam logic [7:0] C_END_BYTE = 8'hC0;
    localparam logic [7:0] C_ESC_BYTE = 8'hDB;
    localparam logic [7:0] C_ESC_END  = 8'hDC;
    localparam logic [7:0] C_ESC_ESC  = 8'hDD;

    localparam logic [15:0] C_CRC_INIT = 16'hFFFF;
    localparam logic [15:0] C_CRC_POLY = 16'h8408;

    localparam int unsigned POS_W   = 11;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned MAX_FRAME = 1024;
    localparam logic [POS_W-1:0] C_LIMIT_CAP = POS_W'(MAX_FRAME);
    localparam logic [POS_W-1:0] C_LIMIT_RESET = 11'd1024;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_CRC_ERR  = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] length;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ C_CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/core/slcd_front.sv]
module slcd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [7:0]                   i_byte,
    input  logic                         i_full,
    input  logic                         i_cfg_valid,
    input  logic [slcd_pkg::POS_W-1:0]   i_cfg_data,
    output logic                         o_stall,
    output logic                         o_push,
    output slcd_pkg::t_result            o_result
);

    logic [slcd_pkg::POS_W-1:0] r_limit;
    logic [slcd_pkg::POS_W-1:0] r_pos;
    logic                       r_esc;
    logic [15:0]                r_crc;

    logic [slcd_pkg::POS_W-1:0] n_pos;
    logic                       n_esc;
    logic [15:0]                n_crc;
    logic                       n_push;
    slcd_pkg::t_result          n_result;
    logic                       accept;
    logic [7:0]                 dec_byte;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_pos    = r_pos;
        n_esc    = r_esc;
        n_crc    = r_crc;
        n_push   = 1'b0;
        n_result = '{kind: slcd_pkg::KIND_DATA, data: 8'h00, index: '0, length: '0};
        dec_byte = i_byte;
        if (r_esc && i_byte == slcd_pkg::C_ESC_END) begin
            dec_byte = slcd_pkg::C_END_BYTE;
        end else if (r_esc && i_byte == slcd_pkg::C_ESC_ESC) begin
            dec_byte = slcd_pkg::C_ESC_BYTE;
        end
        if (i_byte == slcd_pkg::C_ESC_BYTE) begin
            n_esc = 1'b1;
        end else if (i_byte == slcd_pkg::C_END_BYTE) begin
            n_pos = '0;
            n_esc = 1'b0;
            n_crc = slcd_pkg::C_CRC_INIT;
            if (r_pos >= slcd_pkg::POS_W'(2)) begin
                n_push = 1'b1;
                if (r_crc == 16'h0000) begin
                    n_result.kind   = slcd_pkg::KIND_GOOD;
                    n_result.length = slcd_pkg::IDX_W'(r_pos - slcd_pkg::POS_W'(2));
                end else begin
                    n_result.kind = slcd_pkg::KIND_CRC_ERR;
                end
            end
        end else if (r_pos < r_limit) begin
            n_push         = 1'b1;
            n_result.data  = dec_byte;
            n_result.index = r_pos[slcd_pkg::IDX_W-1:0];
            n_crc          = slcd_pkg::crc_byte(r_crc, dec_byte);
            n_pos          = r_pos + slcd_pkg::POS_W'(1);
            n_esc          = 1'b0;
        end else begin
            n_push        = 1'b1;
            n_result.kind = slcd_pkg::KIND_OVERFLOW;
            n_pos         = '0;
            n_esc         = 1'b0;
            n_crc         = slcd_pkg::C_CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= slcd_pkg::C_LIMIT_RESET;
            r_pos   <= '0;
            r_esc   <= 1'b0;
            r_crc   <= slcd_pkg::C_CRC_INIT;
        end else if (i_cfg_valid) begin
            r_limit <= (i_cfg_data > slcd_pkg::C_LIMIT_CAP) ? slcd_pkg::C_LIMIT_CAP : i_cfg_data;
            r_pos   <= '0;
            r_esc   <= 1'b0;
            r_crc   <= slcd_pkg::C_CRC_INIT;
        end else if (accept) begin
            r_pos <= n_pos;
            r_esc <= n_esc;
            r_crc <= n_crc;
        end
    end

    assign o_push   = accept && n_push;
    assign o_result = n_result;

    property p_limit_capped;
        @(posedge i_clk) disable iff (!i_rst_n) r_limit <= slcd_pkg::C_LIMIT_CAP;
    endproperty
    a_limit_capped: assert property (p_limit_capped) else $error("limit above cap");

    property p_pos_bounded;
        @(posedge i_clk) disable iff (!i_rst_n) r_pos <= r_limit || r_pos == '0;
    endproperty
    a_pos_bounded: assert property (p_pos_bounded) else $error("frame position past limit");

    property p_cfg_restart;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_cfg_valid |=> (r_pos == '0 && !r_esc && r_crc == slcd_pkg::C_CRC_INIT);
    endproperty
    a_cfg_restart: assert property (p_cfg_restart) else $error("receiver not restarted");

endmodule

[rtl/core/slcd_queue.sv]
module slcd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  slcd_pkg::t_result i_wr_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_rd_valid,
    output slcd_pkg::t_result o_rd_data
);

    slcd_pkg::t_result                r_mem [slcd_pkg::QUEUE_DEPTH];
    logic [slcd_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [slcd_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [slcd_pkg::QCNT_W-1:0]      r_count;

    assign o_full     = (r_count == slcd_pkg::QCNT_W'(slcd_pkg::QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == slcd_pkg::QPTR_W'(slcd_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + slcd_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == slcd_pkg::QPTR_W'(slcd_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + slcd_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + slcd_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - slcd_pkg::QCNT_W'(1);
            end
        end
    end

    property p_no_push_full;
        @(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full;
    endproperty
    a_no_push_full: assert property (p_no_push_full) else $error("push into full queue");

    property p_no_pop_empty;
        @(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_rd_valid;
    endproperty
    a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");

    property p_count_bounded;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_count <= slcd_pkg::QCNT_W'(slcd_pkg::QUEUE_DEPTH);
    endproperty
    a_count_bounded: assert property (p_count_bounded) else $error("queue count overrun");

endmodule

[rtl/core/slcd_back.sv]
module slcd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_valid,
    input  slcd_pkg::t_result i_rd_data,
    input  logic              i_stall,
    output logic              o_pop,
    output logic              o_valid,
    output slcd_pkg::t_result o_result
);

    logic              r_valid;
    slcd_pkg::t_result r_result;

    assign o_pop    = i_rd_valid && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_rd_data;
        end
    end

endmodule

[rtl/core/slip_crc_frame_decoder.sv]
// The front stage decodes escapes and updates the CRC bytewise combinationally and
// pushes each result into the queue when its byte is accepted; the output register
// driving o_result_valid takes it from the queue head. One line byte per cycle while
// o_line_stall is low; a two-entry queue and the output register absorb result stalls.
// Reset: synchronous, active low; clears the frame, sets buffer_size to 1024,
// empties the queue. Config writes are always ready and restart the frame.
module slip_crc_frame_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_line_valid,
    input  logic [7:0]                  i_line_byte,
    output logic                        o_line_stall,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [10:0]                 i_cfg_buffer_size,
    output logic                        o_result_valid,
    input  logic                        i_result_stall,
    output logic [1:0]                  o_result_kind,
    output logic [7:0]                  o_data_byte,
    output logic [9:0]                  o_byte_index,
    output logic [9:0]                  o_payload_length
);

    logic              full;
    logic              push;
    logic              pop;
    logic              rd_valid;
    slcd_pkg::t_result wr_data;
    slcd_pkg::t_result rd_data;
    slcd_pkg::t_result out_result;

    assign o_cfg_ready = 1'b1;

    slcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_line_valid),
        .i_byte      (i_line_byte),
        .i_full      (full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_buffer_size),
        .o_stall     (o_line_stall),
        .o_push      (push),
        .o_result    (wr_data)
    );

    slcd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_wr_data  (wr_data),
        .i_pop      (pop),
        .o_full     (full),
        .o_rd_valid (rd_valid),
        .o_rd_data  (rd_data)
    );

    slcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_valid (rd_valid),
        .i_rd_data  (rd_data),
        .i_stall    (i_result_stall),
        .o_pop      (pop),
        .o_valid    (o_result_valid),
        .o_result   (out_result)
    );

    assign o_result_kind    = out_result.kind;
    assign o_data_byte      = out_result.data;
    assign o_byte_index     = out_result.index;
    assign o_payload_length = out_result.length;

endmodule

[test/slip_crc_frame_decoder_test.sv]
module slip_crc_frame_decoder_test;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASE_BYTES     = 32;
    localparam int PHASE_COUNT     = 9;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    typedef struct packed {
        logic              is_cfg;
        logic [10:0]       value;
        logic              typed;
        logic              typed_has;
        slcd_pkg::t_result want;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_line_valid;
    logic [7:0] i_line_byte;
    logic       o_line_stall;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [10:0] i_cfg_buffer_size;
    logic       o_result_valid;
    logic       i_result_stall;
    logic [1:0] o_result_kind;
    logic [7:0] o_data_byte;
    logic [9:0] o_byte_index;
    logic [9:0] o_payload_length;

    // frame decoder state tracked alongside the block
    logic [10:0] frame_limit;
    logic [10:0] frame_pos;
    logic        esc_pending;
    logic [15:0] frame_crc;

    slcd_pkg::t_result expected_results [$];
    t_stim_row         directed_rows [$];
    t_stim_row         cur_row = '0;
    slcd_pkg::t_result predicted;
    bit                produced;

    bit hold_off_req = 1'b0;
    int burst_left   = 0;
    int bytes_sent   = 0;
    int lines_taken  = 0;
    int results_checked = 0;
    int cfg_writes   = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;
    int kind_seen [4];
    bit quiet;

    slip_crc_frame_decoder DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_line_valid      (i_line_valid),
        .i_line_byte       (i_line_byte),
        .o_line_stall      (o_line_stall),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_buffer_size (i_cfg_buffer_size),
        .o_result_valid    (o_result_valid),
        .i_result_stall    (i_result_stall),
        .o_result_kind     (o_result_kind),
        .o_data_byte       (o_data_byte),
        .o_byte_index      (o_byte_index),
        .o_payload_length  (o_payload_length)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8) acc = (acc >> 1) ^ (acc[0] ? slcd_pkg::C_CRC_POLY : 16'h0000);
        return acc;
    endfunction

    function automatic void restart_frame();
        frame_pos   = '0;
        esc_pending = 1'b0;
        frame_crc   = slcd_pkg::C_CRC_INIT;
    endfunction

    function automatic bit decode_line_byte(input logic [7:0] raw,
                                            output slcd_pkg::t_result r);
        logic [7:0]  d;
        logic [10:0] cap;
        r   = '0;
        cap = (frame_limit > slcd_pkg::C_LIMIT_CAP) ? slcd_pkg::C_LIMIT_CAP : frame_limit;
        if (raw == slcd_pkg::C_ESC_BYTE) begin
            esc_pending = 1'b1;
            return 1'b0;
        end
        if (raw == slcd_pkg::C_END_BYTE) begin
            if (frame_pos < 11'd2) begin
                restart_frame();
                return 1'b0;
            end
            r.kind = (frame_crc == 16'h0000) ? slcd_pkg::KIND_GOOD : slcd_pkg::KIND_CRC_ERR;
            if (r.kind == slcd_pkg::KIND_GOOD) r.length = 10'(frame_pos - 11'd2);
            restart_frame();
            return 1'b1;
        end
        if (frame_pos < cap) begin
            d = raw;
            if (esc_pending && raw == slcd_pkg::C_ESC_END) d = slcd_pkg::C_END_BYTE;
            else if (esc_pending && raw == slcd_pkg::C_ESC_ESC) d = slcd_pkg::C_ESC_BYTE;
            esc_pending = 1'b0;
            r.data      = d;
            r.index     = frame_pos[9:0];
            frame_crc   = crc_step(frame_crc, d);
            frame_pos   = frame_pos + 11'd1;
            return 1'b1;
        end
        restart_frame();
        r.kind = slcd_pkg::KIND_OVERFLOW;
        return 1'b1;
    endfunction

    function automatic void check_result();
        slcd_pkg::t_result want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d data %02h index %0d length %0d",
                         o_result_kind, o_data_byte, o_byte_index, o_payload_length);
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        kind_seen[want.kind]++;
        if (o_result_kind !== want.kind || o_data_byte !== want.data ||
            o_byte_index !== want.index || o_payload_length !== want.length) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp k%0d d%02h i%0d l%0d, got k%0d d%02h i%0d l%0d",
                         want.kind, want.data, want.index, want.length,
                         o_result_kind, o_data_byte, o_byte_index, o_payload_length);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet = 1'b1;
            if (o_result_valid === 1'b1 && i_result_stall === 1'b0) begin
                check_result();
                quiet = 1'b0;
            end
            if (i_line_valid && o_line_stall === 1'b0) begin
                produced = decode_line_byte(i_line_byte, predicted);
                if (cur_row.typed) begin
                    if (cur_row.typed_has) expected_results.push_back(cur_row.want);
                end else if (produced) begin
                    expected_results.push_back(predicted);
                end
                lines_taken++;
                quiet = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                frame_limit = i_cfg_buffer_size;
                restart_frame();
                cfg_writes++;
                quiet = 1'b0;
            end
            // count a cycle with no transaction on any channel
            if (quiet) idle_cycles++;
            else idle_cycles = 0;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : result_stall_gen
        t_stall_mode mode;
        int left;
        int period;
        int tick;
        i_result_stall = 1'b0;
        mode   = STALL_NONE;
        left   = 0;
        period = 2;
        tick   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            if (left == 0) begin
                mode   = t_stall_mode'($urandom_range(0, 3));
                left   = $urandom_range(64, 256);
                period = $urandom_range(2, 9);
            end
            left--;
            tick++;
            case (mode)
                STALL_NONE:  i_result_stall <= 1'b0;
                STALL_LIGHT: i_result_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_result_stall <= ($urandom_range(0, 3) != 0);
                default:     i_result_stall <= ((tick % period) == 0);
            endcase
        end
    end

    function automatic t_stim_row checked_byte(input logic [7:0] b);
        t_stim_row r;
        r = '0;
        r.value = {3'b000, b};
        return r;
    endfunction

    function automatic t_stim_row silent_byte(input logic [7:0] b);
        t_stim_row r;
        r = checked_byte(b);
        r.typed = 1'b1;
        return r;
    endfunction

    function automatic t_stim_row typed_byte(input logic [7:0] b, input slcd_pkg::t_kind k,
                                             input logic [7:0] d, input logic [9:0] ix,
                                             input logic [9:0] ln);
        t_stim_row r;
        r = silent_byte(b);
        r.typed_has   = 1'b1;
        r.want.kind   = k;
        r.want.data   = d;
        r.want.index  = ix;
        r.want.length = ln;
        return r;
    endfunction

    function automatic t_stim_row cfg_entry(input logic [10:0] v);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.value  = v;
        return r;
    endfunction

    function automatic logic [7:0] pick_payload_byte();
        case ($urandom_range(0, 11))
            0:       return slcd_pkg::C_END_BYTE;
            1:       return slcd_pkg::C_ESC_BYTE;
            2:       return slcd_pkg::C_ESC_END;
            3:       return slcd_pkg::C_ESC_ESC;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == slcd_pkg::C_END_BYTE || b == slcd_pkg::C_ESC_BYTE) b = b ^ 8'h01;
        return b;
    endfunction

    task automatic send_line_byte(input t_stim_row row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0 && !hold_off_req) begin
                i_line_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_line_valid <= 1'b1;
        i_line_byte  <= row.value[7:0];
        cur_row      <= row;
        do @(posedge i_clk); while (o_line_stall !== 1'b0);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_line_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_buffer_size(input logic [10:0] v);
        wait_drained();
        i_cfg_valid       <= 1'b1;
        i_cfg_buffer_size <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_decoded(input logic [7:0] d);
        if (d == slcd_pkg::C_END_BYTE || d == slcd_pkg::C_ESC_BYTE) begin
            send_line_byte(checked_byte(slcd_pkg::C_ESC_BYTE));
            send_line_byte(checked_byte((d == slcd_pkg::C_END_BYTE) ?
                                        slcd_pkg::C_ESC_END : slcd_pkg::C_ESC_ESC));
        end else begin
            if (d != slcd_pkg::C_ESC_END && d != slcd_pkg::C_ESC_ESC &&
                $urandom_range(0, 9) == 0)
                send_line_byte(checked_byte(slcd_pkg::C_ESC_BYTE));
            send_line_byte(checked_byte(d));
        end
    endtask

    task automatic send_frame(input int payload_len, input bit corrupt);
        logic [7:0]  body [$];
        logic [15:0] crc;
        int          pos;
        crc = slcd_pkg::C_CRC_INIT;
        for (int i = 0; i < payload_len; i++) begin
            body.push_back(pick_payload_byte());
            crc = crc_step(crc, body[i]);
        end
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        if (corrupt) begin
            pos = $urandom_range(0, body.size() - 1);
            body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (body[i]) send_decoded(body[i]);
        send_line_byte(checked_byte(slcd_pkg::C_END_BYTE));
    endtask

    initial begin : stimulus
        logic [10:0] phase_sizes [PHASE_COUNT];
        int eff;
        int roll;
        int plen;
        int cap;
        int n;
        int phase_end;
        int phase_mid;
        bit paused;

        i_rst_n           = 1'b0;
        i_line_valid      = 1'b0;
        i_line_byte       = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_buffer_size = '0;
        frame_limit       = slcd_pkg::C_LIMIT_RESET;
        restart_frame();

        directed_rows.push_back(silent_byte(slcd_pkg::C_END_BYTE));
        directed_rows.push_back(typed_byte(8'h00, slcd_pkg::KIND_DATA, 8'h00, 10'd0, 10'd0));
        directed_rows.push_back(silent_byte(slcd_pkg::C_END_BYTE));
        directed_rows.push_back(typed_byte(8'hFF, slcd_pkg::KIND_DATA, 8'hFF, 10'd0, 10'd0));
        directed_rows.push_back(typed_byte(8'hFF, slcd_pkg::KIND_DATA, 8'hFF, 10'd1, 10'd0));
        directed_rows.push_back(typed_byte(slcd_pkg::C_END_BYTE, slcd_pkg::KIND_GOOD,
                                           8'h00, 10'd0, 10'd0));
        directed_rows.push_back(silent_byte(slcd_pkg::C_ESC_BYTE));
        directed_rows.push_back(typed_byte(slcd_pkg::C_ESC_END, slcd_pkg::KIND_DATA,
                                           slcd_pkg::C_END_BYTE, 10'd0, 10'd0));
        directed_rows.push_back(silent_byte(slcd_pkg::C_ESC_BYTE));
        directed_rows.push_back(typed_byte(slcd_pkg::C_ESC_ESC, slcd_pkg::KIND_DATA,
                                           slcd_pkg::C_ESC_BYTE, 10'd1, 10'd0));
        directed_rows.push_back(silent_byte(slcd_pkg::C_ESC_BYTE));
        directed_rows.push_back(typed_byte(8'h41, slcd_pkg::KIND_DATA, 8'h41, 10'd2, 10'd0));
        directed_rows.push_back(silent_byte(slcd_pkg::C_ESC_BYTE));
        directed_rows.push_back(silent_byte(slcd_pkg::C_ESC_BYTE));
        directed_rows.push_back(typed_byte(slcd_pkg::C_ESC_END, slcd_pkg::KIND_DATA,
                                           slcd_pkg::C_END_BYTE, 10'd3, 10'd0));
        directed_rows.push_back(checked_byte(slcd_pkg::C_END_BYTE));
        directed_rows.push_back(typed_byte(8'h12, slcd_pkg::KIND_DATA, 8'h12, 10'd0, 10'd0));
        directed_rows.push_back(silent_byte(slcd_pkg::C_ESC_BYTE));
        directed_rows.push_back(silent_byte(slcd_pkg::C_END_BYTE));
        directed_rows.push_back(cfg_entry(11'd2));
        directed_rows.push_back(typed_byte(8'h01, slcd_pkg::KIND_DATA, 8'h01, 10'd0, 10'd0));
        directed_rows.push_back(typed_byte(8'h02, slcd_pkg::KIND_DATA, 8'h02, 10'd1, 10'd0));
        directed_rows.push_back(silent_byte(slcd_pkg::C_ESC_BYTE));
        directed_rows.push_back(typed_byte(8'h03, slcd_pkg::KIND_OVERFLOW,
                                           8'h00, 10'd0, 10'd0));
        directed_rows.push_back(cfg_entry(11'd0));
        directed_rows.push_back(typed_byte(8'h05, slcd_pkg::KIND_OVERFLOW,
                                           8'h00, 10'd0, 10'd0));
        directed_rows.push_back(silent_byte(slcd_pkg::C_END_BYTE));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) write_buffer_size(directed_rows[i].value);
            else send_line_byte(directed_rows[i]);
        end

        // fill a frame to the saturated limit, then overflow at the cap
        write_buffer_size(11'h7FF);
        repeat (1025) send_line_byte(checked_byte(plain_byte()));
        send_line_byte(checked_byte(slcd_pkg::C_END_BYTE));

        phase_sizes = '{11'd2, 11'd3, 11'd1, 11'd0, 11'($urandom_range(4, 24)),
                        11'($urandom_range(25, 200)), 11'd1024, 11'h7FF,
                        11'($urandom_range(2, 16))};

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_buffer_size(phase_sizes[ph]);
            if (ph == 5) hold_off_req = 1'b1;
            eff = (frame_limit > slcd_pkg::C_LIMIT_CAP) ? int'(slcd_pkg::C_LIMIT_CAP)
                                                         : int'(frame_limit);
            phase_end = bytes_sent + PHASE_BYTES;
            phase_mid = bytes_sent + PHASE_BYTES / 2;
            paused    = 1'b0;
            while (bytes_sent < phase_end) begin
                if (!paused && bytes_sent >= phase_mid) begin
                    wait_drained();
                    paused = 1'b1;
                end
                roll = $urandom_range(0, 99);
                if (roll < 65) begin
                    cap = (roll < 5) ? 80 : 40;
                    if (eff >= 2) plen = $urandom_range(0, (eff - 2 < cap) ? eff - 2 : cap);
                    else plen = $urandom_range(0, 2);
                    send_frame(plen, $urandom_range(0, 3) == 0);
                end else if (roll < 75) begin
                    n = (eff <= 64) ? eff + $urandom_range(1, 3) : $urandom_range(1, 8);
                    repeat (n) send_line_byte(checked_byte(plain_byte()));
                    send_line_byte(checked_byte(slcd_pkg::C_END_BYTE));
                end else if (roll < 88) begin
                    repeat ($urandom_range(1, 8)) send_line_byte(checked_byte(8'($urandom)));
                end else begin
                    repeat ($urandom_range(0, 4))
                        send_line_byte(checked_byte(pick_payload_byte()));
                    send_line_byte(checked_byte(slcd_pkg::C_ESC_BYTE));
                    send_line_byte(checked_byte(pick_payload_byte()));
                    send_line_byte(checked_byte(slcd_pkg::C_END_BYTE));
                end
            end
        end

        wait_drained();

        $display("covered %0d line bytes and %0d results over %0d buffer size writes",
                 lines_taken, results_checked, cfg_writes);
        $display("kinds: %0d data, %0d good, %0d crc error, %0d overflow; %0d mismatches",
                 kind_seen[slcd_pkg::KIND_DATA], kind_seen[slcd_pkg::KIND_GOOD],
                 kind_seen[slcd_pkg::KIND_CRC_ERR], kind_seen[slcd_pkg::KIND_OVERFLOW],
                 mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/slcd_pkg.sv
rtl/core/slcd_front.sv
rtl/core/slcd_queue.sv
rtl/core/slcd_back.sv
rtl/core/slip_crc_frame_decoder.sv
test/slip_crc_frame_decoder_test.sv
